FILE: src/irphc_pkg.sv
// Shared widths, codes and types of the IR proximity hysteresis classifier.
package irphc_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int LEVEL_W      = 2;
  localparam int REG10_W      = 10;
  localparam int REG16_W      = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int AVG_COUNT_DEF = 8;

  // Only the low SAMPLE_BITS of a reading are kept.
  localparam int SAMPLE_BITS  = 10;
  localparam int DATA_W       = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_MARGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_REL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_REL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_SETTLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SETTLE = 3'd6;

  localparam logic [REG10_W-1:0] BASELINE_RST = 10'd1023;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_NONE  = 2'd0,
    LVL_NEAR  = 2'd1,
    LVL_CLOSE = 2'd2
  } level_t;

endpackage

FILE: src/irphc_in_if.sv
// Sample channel: valid/ready handshake carrying one raw sensor reading.
interface irphc_in_if;
  logic                          valid;
  logic                          ready;
  logic [irphc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: src/irphc_out_if.sv
// Result channel: valid/ready handshake carrying one classification item.
interface irphc_out_if;
  logic                          valid;
  logic                          ready;
  logic [irphc_pkg::LEVEL_W-1:0] level;
  logic [irphc_pkg::REG10_W-1:0] averaged_value;
  logic [irphc_pkg::REG10_W-1:0] block_index;

  modport source (output valid, output level, output averaged_value, output block_index,
                  input ready);
  modport sink   (input valid, input level, input averaged_value, input block_index,
                  output ready);
endinterface

FILE: src/ir_proximity_hysteresis_classifier.sv
// Three-level IR proximity classifier with release hysteresis and settle/confirm.
// Throughput: one sample per cycle unless back-pressure on out fills the pipeline;
//   in.ready drops in the cycle after each cfg write while the scaled thresholds reload.
// Pipeline: a group's last sample passes the decision, reciprocal multiply and
//   result registers in that order before its result is valid on out; the result
//   register frees the input.
// Reset (synchronous, rst_n low): registers to their defaults, level none,
//   normal averaging, accumulator and counters cleared, pipeline empty.
module ir_proximity_hysteresis_classifier #(
  parameter int AVG_COUNT = irphc_pkg::AVG_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  irphc_in_if.sink                       in_ch,
  irphc_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [irphc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [irphc_pkg::CFG_W-1:0]     cfg_wdata
);
  import irphc_pkg::*;

  localparam int CLOG   = $clog2(AVG_COUNT);
  localparam int CNTW   = (CLOG > 0) ? CLOG : 1;
  localparam int SUMW   = DATA_W + CLOG;
  localparam int TW     = SUMW + 3;
  localparam int MW     = SUMW + 2;
  localparam int PW     = SUMW + MW;
  localparam int DIV_SH = SUMW + CLOG;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SH) + longint'(AVG_COUNT) - 64'd1) / longint'(AVG_COUNT);
  localparam logic [MW-1:0]   RECIP    = MW'(RECIP_L);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(AVG_COUNT - 1);

  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_SETTLE  = 2'd1,
    PH_CONFIRM = 2'd2
  } phase_t;

  // configuration registers
  logic [REG10_W-1:0] base_r, cmargin_r, nmargin_r, nrel_off_r, crel_off_r;
  logic [REG16_W-1:0] nsettle_r, csettle_r;
  logic               cfg_hold_r;

  // thresholds scaled by AVG_COUNT, compared against the raw group sum
  logic signed [TW-1:0] cthr_s_r, nthr_s_r, nrel_s_r, crel_s_r;
  logic signed [TW-1:0] cthr_s_nxt, nthr_s_nxt, nrel_s_nxt, crel_s_nxt;
  logic signed [11:0]   cthr, nthr, nrel, crel;
  logic signed [TW-1:0] navg;

  // classifier state
  logic [SUMW-1:0]    sum_r;
  logic [CNTW-1:0]    cnt_r;
  level_t             lvl_r;
  phase_t             phase_r;
  logic [REG16_W-1:0] settle_r;
  logic               pend_close_r;

  // pipeline
  logic               v1_r, v2_r, ov_r;
  level_t             lvl1_r, lvl2_r, olvl_r;
  logic [SUMW-1:0]    sum1_r;
  logic [PW-1:0]      prod2_r;
  logic [REG10_W-1:0] oavg_r, oidx_r;

  logic               acc, ld_out, free2, free1, mv1, mv2;
  logic [SUMW-1:0]    sum_new;
  logic signed [TW-1:0] sum_sx;
  logic               grp_done, ge_nrel, ge_crel, lt_cthr, lt_nthr;
  logic               emit, start, start_close;
  level_t             lvl_dec;
  logic [REG16_W-1:0] settle_load, settle_dec;
  logic [DATA_W-1:0]  avg2;
  logic signed [REG10_W+1:0] idx_full;

  // handshake and stage movement
  assign ld_out = !ov_r || out_ch.ready;
  assign mv2    = v2_r && ld_out;
  assign free2  = !v2_r || ld_out;
  assign mv1    = v1_r && free2;
  assign free1  = !v1_r || free2;
  assign in_ch.ready = free1 && !cfg_hold_r;
  assign acc    = in_ch.valid && in_ch.ready;

  // thresholds, all signed
  always_comb begin
    cthr = $signed({2'b00, base_r}) - $signed({2'b00, cmargin_r});
    nthr = $signed({2'b00, base_r}) - $signed({2'b00, nmargin_r});
    nrel = nthr + $signed({2'b00, nrel_off_r});
    crel = cthr + $signed({2'b00, crel_off_r});
    navg = TW'(AVG_COUNT);
    cthr_s_nxt = TW'(cthr) * navg;
    nthr_s_nxt = TW'(nthr) * navg;
    nrel_s_nxt = TW'(nrel) * navg;
    crel_s_nxt = TW'(crel) * navg;
  end

  assign sum_new  = sum_r + SUMW'(in_ch.sample[DATA_W-1:0]);
  assign sum_sx   = $signed(TW'(sum_new));
  assign grp_done = (cnt_r == CNT_LAST);
  assign ge_nrel  = (sum_sx >= nrel_s_r);
  assign ge_crel  = (sum_sx >= crel_s_r);
  assign lt_cthr  = (sum_sx < cthr_s_r);
  assign lt_nthr  = (sum_sx < nthr_s_r);

  // decision for a completed group
  always_comb begin
    emit        = 1'b0;
    start       = 1'b0;
    start_close = 1'b0;
    lvl_dec     = lvl_r;
    if (phase_r != PH_SETTLE && grp_done) begin
      if (phase_r == PH_CONFIRM) begin
        emit = 1'b1;
        priority if (pend_close_r) lvl_dec = ge_crel ? LVL_NEAR : LVL_CLOSE;
        else if (ge_nrel)          lvl_dec = LVL_NONE;
        else if (lt_cthr)          lvl_dec = LVL_CLOSE;
        else                       lvl_dec = LVL_NEAR;
      end else begin
        case (lvl_r)
          LVL_CLOSE: begin
            if (ge_crel) begin
              start       = 1'b1;
              start_close = 1'b1;
            end else begin
              emit    = 1'b1;
              lvl_dec = LVL_CLOSE;
            end
          end
          LVL_NEAR: begin
            priority if (lt_cthr) begin
              emit    = 1'b1;
              lvl_dec = LVL_CLOSE;
            end else if (ge_nrel) begin
              start = 1'b1;
            end else begin
              emit    = 1'b1;
              lvl_dec = LVL_NEAR;
            end
          end
          default: begin
            emit = 1'b1;
            priority if (lt_cthr) lvl_dec = LVL_CLOSE;
            else if (lt_nthr)     lvl_dec = LVL_NEAR;
            else                  lvl_dec = LVL_NONE;
          end
        endcase
      end
    end
  end

  assign settle_load = start_close ? csettle_r : nsettle_r;
  assign settle_dec  = (settle_r != '0) ? settle_r - 16'd1 : settle_r;

  // control state, configuration and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= BASELINE_RST;
      cmargin_r    <= '0;
      nmargin_r    <= '0;
      nrel_off_r   <= '0;
      crel_off_r   <= '0;
      nsettle_r    <= '0;
      csettle_r    <= '0;
      cfg_hold_r   <= 1'b1;
      sum_r        <= '0;
      cnt_r        <= '0;
      lvl_r        <= LVL_NONE;
      phase_r      <= PH_NORMAL;
      settle_r     <= '0;
      pend_close_r <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_BASELINE:     base_r     <= cfg_wdata[REG10_W-1:0];
          CFG_CLOSE_MARGIN: cmargin_r  <= cfg_wdata[REG10_W-1:0];
          CFG_NEAR_MARGIN:  nmargin_r  <= cfg_wdata[REG10_W-1:0];
          CFG_NEAR_REL:     nrel_off_r <= cfg_wdata[REG10_W-1:0];
          CFG_CLOSE_REL:    crel_off_r <= cfg_wdata[REG10_W-1:0];
          CFG_NEAR_SETTLE:  nsettle_r  <= cfg_wdata[REG16_W-1:0];
          CFG_CLOSE_SETTLE: csettle_r  <= cfg_wdata[REG16_W-1:0];
          default: ;
        endcase
      end

      if (acc) begin
        if (phase_r == PH_SETTLE) begin
          // drop the sample, count down the settle window
          settle_r <= settle_dec;
          if (settle_dec == '0) phase_r <= PH_CONFIRM;
        end else begin
          sum_r <= grp_done ? '0 : sum_new;
          cnt_r <= grp_done ? '0 : cnt_r + CNTW'(1);
          if (grp_done) begin
            if (start) begin
              pend_close_r <= start_close;
              settle_r     <= settle_load;
              phase_r      <= (settle_load == '0) ? PH_CONFIRM : PH_SETTLE;
            end else begin
              phase_r <= PH_NORMAL;
            end
            if (emit) lvl_r <= lvl_dec;
          end
        end
      end

      v1_r <= (acc && emit) || (v1_r && !free2);
      v2_r <= mv1 || (v2_r && !ld_out);
      ov_r <= mv2 || (ov_r && !out_ch.ready);
    end
  end

  assign avg2     = prod2_r[DIV_SH +: DATA_W];
  assign idx_full = $signed({2'b00, base_r}) - $signed({2'b00, REG10_W'(avg2)});

  // payload: thresholds and pipeline data
  always_ff @(posedge clk) begin
    cthr_s_r <= cthr_s_nxt;
    nthr_s_r <= nthr_s_nxt;
    nrel_s_r <= nrel_s_nxt;
    crel_s_r <= crel_s_nxt;
    if (acc && emit) begin
      lvl1_r <= lvl_dec;
      sum1_r <= sum_new;
    end
    if (mv1) begin
      lvl2_r  <= lvl1_r;
      prod2_r <= PW'(sum1_r) * PW'(RECIP);
    end
    if (mv2) begin
      olvl_r <= lvl2_r;
      oavg_r <= REG10_W'(avg2);
      oidx_r <= idx_full[REG10_W+1] ? '0 : idx_full[REG10_W-1:0];
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.level          = olvl_r;
  assign out_ch.averaged_value = oavg_r;
  assign out_ch.block_index    = oidx_r;

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("sample taken while thresholds reload");

  a_settle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_SETTLE) |=> !v1_r)
    else $error("result produced from a settle sample");

  a_settle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SETTLE) |-> (settle_r != '0))
    else $error("settle phase with empty counter");

  a_grp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("group counter past last sample");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the IR proximity hysteresis classifier.
`timescale 1ns / 100ps

module tb_top;
  import irphc_pkg::*;

  localparam int AVG_N          = AVG_COUNT_DEF;
  localparam int IDLE_PCT       = 28;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int QUIET_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int NUM_SETTINGS   = 8;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

  typedef enum logic [1:0] {TRK_AVERAGE, TRK_SETTLE, TRK_CONFIRM} track_t;

  typedef struct packed {
    level_t             level;
    logic [REG10_W-1:0] avg;
    logic [REG10_W-1:0] blk;
  } decision_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] s;
    bit                  typed;
    decision_t           want;
  } drill_row_t;

  typedef struct packed {
    logic [REG10_W-1:0] baseline;
    logic [REG10_W-1:0] close_margin;
    logic [REG10_W-1:0] near_margin;
    logic [REG10_W-1:0] near_rel_off;
    logic [REG10_W-1:0] close_rel_off;
    logic [REG16_W-1:0] near_settle;
    logic [REG16_W-1:0] close_settle;
    logic [7:0]         groups;
    bit                 steady;
    bit                 hold_off;
    bit                 shuffle;
  } setting_t;

  localparam decision_t NO_DEC = '{LVL_NONE, 10'd0, 10'd0};

  // Reset thresholds all sit at 1023: anything below full scale reads as close.
  localparam drill_row_t DRILL [24] = '{
    '{10'd1023, 1'b0, NO_DEC}, '{10'd1023, 1'b0, NO_DEC},
    '{10'd1023, 1'b0, NO_DEC}, '{10'd1023, 1'b0, NO_DEC},
    '{10'd1023, 1'b0, NO_DEC}, '{10'd1023, 1'b0, NO_DEC},
    '{10'd1023, 1'b0, NO_DEC}, '{10'd1023, 1'b1, '{LVL_NONE, 10'd1023, 10'd0}},
    '{10'd0,    1'b0, NO_DEC}, '{10'd0,    1'b0, NO_DEC},
    '{10'd0,    1'b0, NO_DEC}, '{10'd0,    1'b0, NO_DEC},
    '{10'd0,    1'b0, NO_DEC}, '{10'd0,    1'b0, NO_DEC},
    '{10'd0,    1'b0, NO_DEC}, '{10'd7,    1'b1, '{LVL_CLOSE, 10'd0, 10'd1023}},
    '{10'd1023, 1'b0, NO_DEC}, '{10'd1023, 1'b0, NO_DEC},
    '{10'd1023, 1'b0, NO_DEC}, '{10'd1022, 1'b0, NO_DEC},
    '{10'd1023, 1'b0, NO_DEC}, '{10'd1023, 1'b0, NO_DEC},
    '{10'd1023, 1'b0, NO_DEC}, '{10'd1023, 1'b1, '{LVL_CLOSE, 10'd1022, 10'd1}}
  };

  localparam setting_t SETTINGS_ROWS [NUM_SETTINGS] = '{
    '{10'd800,  10'd300,  10'd100,  10'd50,   10'd60,   16'd0,     16'd0,     8'd20,
      1'b0, 1'b0, 1'b0},
    '{10'd0,    10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'd3,     16'd5,     8'd18,
      1'b0, 1'b0, 1'b0},
    '{10'd1023, 10'd700,  10'd300,  10'd200,  10'd150,  16'd1,     16'd2,     8'd18,
      1'b0, 1'b0, 1'b0},
    '{10'd600,  10'd200,  10'd80,   10'd30,   10'd40,   16'd2,     16'd0,     8'd16,
      1'b1, 1'b1, 1'b0},
    '{10'd700,  10'd250,  10'd100,  10'd20,   10'd20,   16'd24,    16'd16,    8'd4,
      1'b1, 1'b0, 1'b0},
    '{10'd512,  10'd0,    10'd0,    10'd0,    10'd0,    16'd0,     16'd0,     8'd16,
      1'b0, 1'b0, 1'b0},
    '{10'd0,    10'd0,    10'd0,    10'd0,    10'd0,    16'd0,     16'd0,     8'd12,
      1'b0, 1'b0, 1'b1},
    '{10'd0,    10'd0,    10'd0,    10'd0,    10'd0,    16'd0,     16'd0,     8'd12,
      1'b0, 1'b0, 1'b1}
  };

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  irphc_in_if  in_ch();
  irphc_out_if out_ch();

  ir_proximity_hysteresis_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Register mirror.
  logic [REG10_W-1:0] m_baseline;
  logic [REG10_W-1:0] m_close_margin;
  logic [REG10_W-1:0] m_near_margin;
  logic [REG10_W-1:0] m_near_rel_off;
  logic [REG10_W-1:0] m_close_rel_off;
  logic [REG16_W-1:0] m_near_settle;
  logic [REG16_W-1:0] m_close_settle;

  // Classifier state.
  logic [12:0]        running_sum;
  int                 group_fill;
  level_t             held_level;
  track_t             track;
  logic [REG16_W-1:0] settle_left;
  bit                 release_from_close;

  decision_t decisions_due[$];

  bit steady_run;
  bit hold_off_req;
  int mismatches;
  int samples_in;
  int settle_samples;
  int decisions_seen;
  int releases;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got, want, decisions_seen);
  endtask

  function automatic void issue_decision(input level_t lvl, input int a, output decision_t d);
    int idx;
    idx = int'(m_baseline) - a;
    if (idx < 0) idx = 0;
    held_level = lvl;
    d.level = lvl;
    d.avg   = a[REG10_W-1:0];
    d.blk   = idx[REG10_W-1:0];
  endfunction

  function automatic void start_release(input bit from_close);
    release_from_close = from_close;
    settle_left = from_close ? m_close_settle : m_near_settle;
    track = (settle_left == '0) ? TRK_CONFIRM : TRK_SETTLE;
    releases++;
  endfunction

  // Advance the classifier by one sample; returns 1 when a decision comes out.
  function automatic bit classify_sample(input logic [SAMPLE_W-1:0] s, output decision_t d);
    int a;
    int close_thr;
    int near_thr;
    int near_rel;
    int close_rel;
    d = NO_DEC;
    if (track == TRK_SETTLE) begin
      if (settle_left != '0) settle_left--;
      if (settle_left == '0) track = TRK_CONFIRM;
      return 1'b0;
    end
    running_sum += s[DATA_W-1:0];
    group_fill++;
    if (group_fill < AVG_N) return 1'b0;
    a = int'(running_sum) / AVG_N;
    running_sum = '0;
    group_fill = 0;
    close_thr = int'(m_baseline) - int'(m_close_margin);
    near_thr  = int'(m_baseline) - int'(m_near_margin);
    near_rel  = near_thr + int'(m_near_rel_off);
    close_rel = close_thr + int'(m_close_rel_off);

    if (track == TRK_CONFIRM) begin
      track = TRK_AVERAGE;
      if (release_from_close) issue_decision((a >= close_rel) ? LVL_NEAR : LVL_CLOSE, a, d);
      else if (a >= near_rel) issue_decision(LVL_NONE, a, d);
      else if (a < close_thr) issue_decision(LVL_CLOSE, a, d);
      else issue_decision(LVL_NEAR, a, d);
      return 1'b1;
    end

    case (held_level)
      LVL_CLOSE: begin
        if (a >= close_rel) begin
          start_release(1'b1);
          return 1'b0;
        end
        issue_decision(LVL_CLOSE, a, d);
      end
      LVL_NEAR: begin
        if (a < close_thr) begin
          issue_decision(LVL_CLOSE, a, d);
        end else if (a >= near_rel) begin
          start_release(1'b0);
          return 1'b0;
        end else begin
          issue_decision(LVL_NEAR, a, d);
        end
      end
      default: begin
        if (a < close_thr) issue_decision(LVL_CLOSE, a, d);
        else if (a < near_thr) issue_decision(LVL_NEAR, a, d);
        else issue_decision(LVL_NONE, a, d);
      end
    endcase
    return 1'b1;
  endfunction

  // Offer one sample, hold it until accepted, then queue what it decides (or the typed decision in its place).
  task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                              input decision_t typed_dec);
    decision_t d;
    while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    samples_in++;
    if (track == TRK_SETTLE) settle_samples++;
    if (classify_sample(s, d)) decisions_due.push_back(typed ? typed_dec : d);
  endtask

  // One averaging group aimed at a threshold or a random level, or pure noise; flush any settle window first.
  task automatic offer_group();
    int close_thr;
    int near_thr;
    int near_rel;
    int close_rel;
    int tgt;
    int v;
    bit noise;
    while (track == TRK_SETTLE)
      offer_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX)), 1'b0, NO_DEC);
    close_thr = int'(m_baseline) - int'(m_close_margin);
    near_thr  = int'(m_baseline) - int'(m_near_margin);
    near_rel  = near_thr + int'(m_near_rel_off);
    close_rel = close_thr + int'(m_close_rel_off);
    noise = ($urandom_range(99) < 20);
    case ($urandom_range(6))
      0: tgt = close_thr;
      1: tgt = near_thr;
      2: tgt = near_rel;
      3: tgt = close_rel;
      4, 5: tgt = (held_level == LVL_CLOSE) ? close_rel : near_rel;
      default: tgt = int'($urandom_range(SAMPLE_MAX));
    endcase
    repeat (AVG_N) begin
      v = noise ? int'($urandom_range(SAMPLE_MAX)) : tgt + int'($urandom_range(8)) - 4;
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      offer_sample(v[SAMPLE_W-1:0], 1'b0, NO_DEC);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_BASELINE:     m_baseline      = val[REG10_W-1:0];
      CFG_CLOSE_MARGIN: m_close_margin  = val[REG10_W-1:0];
      CFG_NEAR_MARGIN:  m_near_margin   = val[REG10_W-1:0];
      CFG_NEAR_REL:     m_near_rel_off  = val[REG10_W-1:0];
      CFG_CLOSE_REL:    m_close_rel_off = val[REG10_W-1:0];
      CFG_NEAR_SETTLE:  m_near_settle   = val[REG16_W-1:0];
      CFG_CLOSE_SETTLE: m_close_settle  = val[REG16_W-1:0];
      default: ;
    endcase
  endtask

  // Drop valid, wait out every queued decision, then let the pipeline empty.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result sink: random backpressure (none in steady runs), one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else begin
        out_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    decision_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      decisions_seen++;
      if (decisions_due.size() == 0) begin
        flag_mismatch("result with nothing expected, avg", int'(out_ch.averaged_value), 0);
      end else begin
        want = decisions_due.pop_front();
        if (out_ch.level !== want.level)
          flag_mismatch("level", int'(out_ch.level), int'(want.level));
        if (out_ch.averaged_value !== want.avg)
          flag_mismatch("averaged_value", int'(out_ch.averaged_value), int'(want.avg));
        if (out_ch.block_index !== want.blk)
          flag_mismatch("block_index", int'(out_ch.block_index), int'(want.blk));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || cfg_we === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("ir_proximity_hysteresis_classifier test failed");
    $finish;
  end

  initial begin
    setting_t cur;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_BASELINE;
    cfg_wdata    <= '0;
    steady_run   = 1'b0;
    hold_off_req = 1'b0;
    m_baseline      = BASELINE_RST;
    m_close_margin  = '0;
    m_near_margin   = '0;
    m_near_rel_off  = '0;
    m_close_rel_off = '0;
    m_near_settle   = '0;
    m_close_settle  = '0;
    running_sum        = '0;
    group_fill         = 0;
    held_level         = LVL_NONE;
    track              = TRK_AVERAGE;
    settle_left        = '0;
    release_from_close = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DRILL[i]) offer_sample(DRILL[i].s, DRILL[i].typed, DRILL[i].want);
    drain();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      cur = SETTINGS_ROWS[p];
      if (cur.shuffle) begin
        cur.baseline      = REG10_W'($urandom_range(SAMPLE_MAX));
        cur.close_margin  = REG10_W'($urandom_range(SAMPLE_MAX));
        cur.near_margin   = REG10_W'($urandom_range(SAMPLE_MAX));
        cur.near_rel_off  = REG10_W'($urandom_range(300));
        cur.close_rel_off = REG10_W'($urandom_range(300));
        cur.near_settle   = REG16_W'($urandom_range(12));
        cur.close_settle  = REG16_W'($urandom_range(12));
      end
      write_reg(CFG_BASELINE,     CFG_W'(cur.baseline));
      write_reg(CFG_CLOSE_MARGIN, CFG_W'(cur.close_margin));
      write_reg(CFG_NEAR_MARGIN,  CFG_W'(cur.near_margin));
      write_reg(CFG_NEAR_REL,     CFG_W'(cur.near_rel_off));
      write_reg(CFG_CLOSE_REL,    CFG_W'(cur.close_rel_off));
      write_reg(CFG_NEAR_SETTLE,  CFG_W'(cur.near_settle));
      write_reg(CFG_CLOSE_SETTLE, CFG_W'(cur.close_settle));
      cfg_we <= 1'b0;
      steady_run = cur.steady;
      if (cur.hold_off) hold_off_req = 1'b1;
      repeat (cur.groups) offer_group();
      drain();
      steady_run = 1'b0;
    end

    if (decisions_due.size() != 0)
      flag_mismatch("decisions never delivered", 0, decisions_due.size());
    $display("Covered %0d samples (%0d inside settle windows), %0d decisions, %0d releases,",
             samples_in, settle_samples, decisions_seen, releases);
    $display("  reset setup plus %0d register settings, %0d mismatches", NUM_SETTINGS,
             mismatches);
    if (mismatches == 0) begin
      $display("ir_proximity_hysteresis_classifier test passed");
    end else begin
      $display("ir_proximity_hysteresis_classifier test failed");
    end
    $finish;
  end

endmodule
